### rtl/core/u2j_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package u2j_pkg;

    typedef enum logic [1:0] {
        K_CHAR = 2'd0,
        K_ESC  = 2'd1,
        K_HEX  = 2'd2,
        K_PAIR = 2'd3
    } t_kind;

    // one command per input item that has results
    typedef struct packed {
        t_kind       kind;
        logic [6:0]  ch;
        logic [15:0] hi;
        logic [15:0] lo;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    localparam logic [1:0] MARK_DATA  = 2'd0;
    localparam logic [1:0] MARK_START = 2'd1;
    localparam logic [1:0] MARK_END   = 2'd2;

    localparam logic [6:0] CH_QUOTE = 7'h22;
    localparam logic [6:0] CH_BSL   = 7'h5C;
    localparam logic [6:0] CH_U     = 7'h75;
    localparam logic [6:0] CH_B     = 7'h62;
    localparam logic [6:0] CH_F     = 7'h66;
    localparam logic [6:0] CH_N     = 7'h6E;
    localparam logic [6:0] CH_R     = 7'h72;
    localparam logic [6:0] CH_T     = 7'h74;

    localparam logic [15:0] CP_REPLACEMENT = 16'hFFFD;

endpackage
`default_nettype wire

### rtl/core/u2j_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface u2j_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mark;
    logic [7:0] data_byte;

    modport source (output valid, output mark, output data_byte, input ready);
    modport sink (input valid, input mark, input data_byte, output ready);
endinterface
`default_nettype wire

### rtl/core/u2j_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface u2j_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface
`default_nettype wire

### rtl/core/utf8_to_json_string_escaper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// UTF-8 bytes framed by start and end marks go in, the JSON quoted form comes
// out one ASCII character per cycle while the receiver is ready. The front
// decodes UTF-8 and classifies each finished code point in the cycle its byte
// is taken; a queue of FIFO_DEPTH commands hands them to a sequencer that
// spells them out. Plain characters and marks follow each other back to back;
// a two-character escape, a six-character \uXXXX escape and a twelve-character
// surrogate pair are spelled one character at a time; input stalls once the
// queue fills behind them. Lead and middle bytes of a sequence produce nothing.
// An item's first character comes out through the queue, then the command and output registers.
module utf8_to_json_string_escaper_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    u2j_in_if.sink    i_in,
    u2j_out_if.source o_out
);
    import u2j_pkg::*;

    t_push push;
    t_cmd  q_data;
    logic  q_full;
    logic  q_empty;
    logic  pop;

    u2j_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (push)
    );

    u2j_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    u2j_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (q_data),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

### rtl/core/u2j_front.sv
`timescale 1ns / 1ps
`default_nettype none
module u2j_front (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    u2j_in_if.sink       i_in,
    input  wire logic    i_full,
    output u2j_pkg::t_push o_push
);
    import u2j_pkg::*;

    logic [20:0] r_acc, n_acc;
    logic [1:0]  r_rem, n_rem;
    logic        accept;
    logic        emit;
    logic [20:0] cp;
    t_cmd        cmd;

    function automatic t_cmd classify(input logic [20:0] c);
        t_cmd        r;
        logic [20:0] d;
        r.kind = K_HEX;
        r.ch   = c[6:0];
        r.hi   = c[15:0];
        r.lo   = 16'h0;
        d      = c - 21'h010000;
        case (c)
            21'h22: begin r.kind = K_ESC; r.ch = CH_QUOTE; end
            21'h5C: begin r.kind = K_ESC; r.ch = CH_BSL; end
            21'h08: begin r.kind = K_ESC; r.ch = CH_B; end
            21'h0C: begin r.kind = K_ESC; r.ch = CH_F; end
            21'h0A: begin r.kind = K_ESC; r.ch = CH_N; end
            21'h0D: begin r.kind = K_ESC; r.ch = CH_R; end
            21'h09: begin r.kind = K_ESC; r.ch = CH_T; end
            default: begin
                if (c >= 21'h20 && c <= 21'h7F) begin
                    r.kind = K_CHAR;
                end else if (c > 21'h10FFFF) begin
                    r.hi = CP_REPLACEMENT;
                end else if (c > 21'h00FFFF) begin
                    r.kind = K_PAIR;
                    r.hi   = {6'b110110, d[19:10]};
                    r.lo   = {6'b110111, d[9:0]};
                end
            end
        endcase
        return r;
    endfunction

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        n_acc = r_acc;
        n_rem = r_rem;
        emit  = 1'b0;
        cp    = {13'h0, i_in.data_byte};
        if (i_in.mark == MARK_START || i_in.mark == MARK_END) begin
            n_rem = 2'd0;
            emit  = 1'b1;
        end else if (i_in.mark == MARK_DATA) begin
            if (r_rem != 2'd0) begin
                n_acc = {r_acc[14:0], i_in.data_byte[5:0]};
                n_rem = r_rem - 2'd1;
                cp    = n_acc;
                emit  = (r_rem == 2'd1);
            end else if (!i_in.data_byte[7]) begin
                emit = 1'b1;
            end else if (i_in.data_byte[7:5] == 3'b110) begin
                n_acc = {16'h0, i_in.data_byte[4:0]};
                n_rem = 2'd1;
            end else if (i_in.data_byte[7:4] == 4'b1110) begin
                n_acc = {17'h0, i_in.data_byte[3:0]};
                n_rem = 2'd2;
            end else if (i_in.data_byte[7:3] == 5'b11110) begin
                n_acc = {18'h0, i_in.data_byte[2:0]};
                n_rem = 2'd3;
            end else begin
                // stray continuation or bad lead byte stands for itself
                emit = 1'b1;
            end
        end
    end

    always_comb begin
        cmd = classify(cp);
        if (i_in.mark != MARK_DATA) begin
            cmd.kind = K_CHAR;
            cmd.ch   = CH_QUOTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 21'h0;
            r_rem <= 2'd0;
        end else if (accept) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_push.valid = accept && emit;
    assign o_push.cmd   = cmd;

endmodule
`default_nettype wire

### rtl/core/u2j_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module u2j_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire u2j_pkg::t_push i_push,
    input  wire logic           i_pop,
    output u2j_pkg::t_cmd       o_data,
    output logic                o_full,
    output logic                o_empty
);
    import u2j_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/u2j_back.sv
`timescale 1ns / 1ps
`default_nettype none
module u2j_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire u2j_pkg::t_cmd i_data,
    input  wire logic          i_empty,
    output logic               o_pop,
    u2j_out_if.source          o_out
);
    import u2j_pkg::*;

    logic       r_busy;
    t_cmd       r_cmd;
    logic [3:0] r_idx;
    logic       r_ov;
    logic [6:0] r_och;
    logic       r_olast;

    logic       out_adv;
    logic       emit;
    logic       cur_last;
    logic       load;
    logic [3:0] last_idx;
    logic [6:0] cur_char;
    logic [2:0] pos;
    logic [15:0] val;
    logic [3:0] nib;

    function automatic logic [6:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (7'h30 + {3'b0, n}) : (7'h37 + {3'b0, n});
    endfunction

    always_comb begin
        case (r_cmd.kind)
            K_CHAR:  last_idx = 4'd0;
            K_ESC:   last_idx = 4'd1;
            K_HEX:   last_idx = 4'd5;
            default: last_idx = 4'd11;
        endcase
    end

    // second half of a surrogate pair reuses the hex sequence on lo
    always_comb begin
        if (r_idx >= 4'd6) begin
            pos = 3'(r_idx - 4'd6);
            val = r_cmd.lo;
        end else begin
            pos = r_idx[2:0];
            val = r_cmd.hi;
        end
        case (pos)
            3'd2:    nib = val[15:12];
            3'd3:    nib = val[11:8];
            3'd4:    nib = val[7:4];
            default: nib = val[3:0];
        endcase
        case (r_cmd.kind)
            K_CHAR: cur_char = r_cmd.ch;
            K_ESC:  cur_char = (r_idx == 4'd0) ? CH_BSL : r_cmd.ch;
            default: begin
                if (pos == 3'd0) begin
                    cur_char = CH_BSL;
                end else if (pos == 3'd1) begin
                    cur_char = CH_U;
                end else begin
                    cur_char = hex_char(nib);
                end
            end
        endcase
    end

    assign out_adv  = !r_ov || o_out.ready;
    assign emit     = r_busy && out_adv;
    assign cur_last = (r_idx == last_idx);
    assign load     = !r_busy || (emit && cur_last);
    assign o_pop    = load && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 4'd0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= !i_empty;
                r_idx  <= 4'd0;
            end else if (emit) begin
                r_idx <= r_idx + 4'd1;
            end
            if (out_adv) begin
                r_ov <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_data;
        end
        if (emit) begin
            r_och   <= cur_char;
            r_olast <= cur_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_char    = r_och;
    assign o_out.last_of_run = r_olast;

endmodule
`default_nettype wire
